@@ rtl/asss_pkg.sv @@
// Package: types, codes and constants of the almost Sidon set search.
package asss_pkg;

  localparam int MAX_ELEM_DEF     = 256;
  localparam int MAX_SET_SIZE_DEF = 64;

  localparam logic [8:0]  LIMIT_RST    = 9'd256;
  localparam logic [6:0]  SIZE_RST     = 7'd1;
  localparam logic [31:0] MAX_SETS_RST = 32'd1000000;

  typedef enum logic [1:0] {
    REG_ELEMENT_LIMIT = 2'd0,
    REG_SET_SIZE      = 2'd1,
    REG_MAX_SETS      = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    STAT_FOUND     = 2'd0,
    STAT_EXHAUSTED = 2'd1,
    STAT_LIMIT     = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STEP,
    ST_POP_RD,
    ST_POP_WT,
    ST_SCAN,
    ST_DECIDE,
    ST_HI_RD,
    ST_HI_WT,
    ST_HJ_RD,
    ST_HV,
    ST_HW,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_STATUS
  } state_t;

  typedef struct packed {
    logic restart;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [8:0]        element;
    logic [5:0]        position;
    logic              is_last;
    logic [9:0]        peak_sum;
    logic [6:0]        peak_count;
    logic signed [7:0] invariant;
    logic              anomaly;
  } rsp_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] value;
  } cfg_t;

endpackage

@@ rtl/asss_chan_if.sv @@
// Interface: valid/ready channel carrying one word.
interface asss_chan_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

@@ rtl/almost_sidon_set_search.sv @@
// Top level: resumable depth-first search for almost Sidon sets.
//
// Channels: req carries one restart bit per request; rsp returns the words of
// the answer; cfg writes element_limit (0), set_size (1) and max_sets (2), and
// is always ready. A request is taken only while the search is idle.
// Each request returns the next set, one rsp word per element in ascending
// order with is_last on the final one, or a single status word (exhausted or
// output limit reached).
// Each tried candidate costs a word-serial read-modify-write of the three
// level bitsets (WORDS = 2*MAX_ELEM/64 + 1 words per level); a backtrack
// pops one stack entry. A found set also runs the pair-sum histogram (clear
// pass then count pass, one histogram RAM write per pair, each row first
// fetching its element from the stack) before its words are output.
// The total search time depends on how far the search has to walk.
// Reset: configuration returns to 256 / 1 / 1000000, the search is at the
// empty set, and level zero bitsets read as zero with no clearing pass.
// A stalled rsp holds the current word; the search waits before loading another word until it is taken.
module almost_sidon_set_search
  import asss_pkg::*;
#(
  parameter int MAX_ELEM     = MAX_ELEM_DEF,
  parameter int MAX_SET_SIZE = MAX_SET_SIZE_DEF
) (
  input logic clk,
  input logic rst,
  asss_chan_if.sink   req,
  asss_chan_if.source rsp,
  asss_chan_if.sink   cfg
);
  localparam int WORDS  = (2 * MAX_ELEM) / 64 + 1;
  localparam int LEVELS = MAX_SET_SIZE + 1;
  localparam int MDEPTH = LEVELS * WORDS;
  localparam int AW     = $clog2(MDEPTH);
  localparam int EW     = $clog2(MAX_ELEM + 1);
  localparam int XW     = $clog2(MAX_ELEM + 2);
  localparam int HD     = 2 * MAX_ELEM + 1;
  localparam int VW     = $clog2(HD);
  localparam int SAW    = $clog2(MAX_SET_SIZE + 1);
  localparam int WW     = $clog2(WORDS + 1);

  state_t state, state_next;

  logic [8:0]  element_limit;
  logic [6:0]  set_size;
  logic [31:0] max_sets;

  logic [6:0]    depth;
  logic [XW-1:0] cur;
  logic [XW-1:0] x;
  logic [31:0]   sets_reported;
  logic [1:0]    stat_code;
  logic          pop_idle;

  logic [WW-1:0] w;
  logic          s_val;
  logic [WW-1:0] s_idx;
  logic          s_hi_ok;
  logic          s_lv0;
  logic [63:0]   prev;
  logic [1:0]    fresh;
  logic          excl;

  logic [SAW-1:0] hi, hj, oi;
  logic           pass;
  logic [EW-1:0]  ai;
  logic [VW-1:0]  hv;
  logic [VW-1:0]  peak;
  logic [6:0]     pk_cnt;

  logic          rsp_valid;
  rsp_t          rsp_word;

  logic          shift_we;
  logic [AW-1:0] shift_waddr, shift_raddr, plain_raddr;
  logic [63:0]   member_wdata, shift_rd, plain_rd;
  logic [127:0]  sum_wdata, sum_rd;
  logic          stk_we;
  logic [SAW-1:0] stk_waddr, stk_raddr;
  logic [EW-1:0] stk_wdata, stk_rd;
  logic          hist_we;
  logic [VW-1:0] hist_waddr, hist_raddr;
  logic [6:0]    hist_wdata, hist_rd;

  asss_ram #(.WIDTH(64), .DEPTH(MDEPTH)) u_member_shift (
    .clk, .we(shift_we), .waddr(shift_waddr), .wdata(member_wdata),
    .raddr(shift_raddr), .rdata(shift_rd)
  );
  asss_ram #(.WIDTH(64), .DEPTH(MDEPTH)) u_member_plain (
    .clk, .we(shift_we), .waddr(shift_waddr), .wdata(member_wdata),
    .raddr(plain_raddr), .rdata(plain_rd)
  );
  asss_ram #(.WIDTH(128), .DEPTH(MDEPTH)) u_sums (
    .clk, .we(shift_we), .waddr(shift_waddr), .wdata(sum_wdata),
    .raddr(plain_raddr), .rdata(sum_rd)
  );
  asss_ram #(.WIDTH(EW), .DEPTH(MAX_SET_SIZE + 1)) u_stack (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rd)
  );
  asss_ram #(.WIDTH(7), .DEPTH(HD)) u_hist (
    .clk, .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
    .raddr(hist_raddr), .rdata(hist_rd)
  );

  // search step decode
  logic [XW-1:0] n_lim;
  logic          size_bad, out_range, rsp_free, reject, rsp_load;
  logic [11:0]   bound_l, bound_r;
  logic [15:0]   x16, x2;
  logic [9:0]    ws;
  logic [5:0]    bsh;
  logic [AW-1:0] base, base_up;

  assign n_lim     = (10'(element_limit) > 10'(MAX_ELEM)) ? XW'(MAX_ELEM) : XW'(element_limit);
  assign size_bad  = (set_size == 7'd0) || (set_size > 7'(MAX_SET_SIZE));
  assign bound_l   = 12'(depth) + 12'd1 + 12'(n_lim);
  assign bound_r   = 12'(set_size) + 12'(cur);
  assign out_range = (cur > n_lim) || (bound_l < bound_r);
  assign rsp_free  = !rsp_valid || rsp.ready;
  assign rsp_load  = (state == ST_OUT_LD) || ((state == ST_STATUS) && rsp_free);
  assign reject    = (fresh == 2'd2) || ((fresh == 2'd1) && excl);
  assign x16       = 16'(x);
  assign x2        = x16 << 1;
  assign ws        = x16[15:6];
  assign bsh       = x16[5:0];
  assign base      = AW'(depth) * AW'(WORDS);
  assign base_up   = AW'(depth + 7'd1) * AW'(WORDS);

  // word datapath
  logic [63:0] hi_word, plain_w, once_w, twice_w, fnew, hits, fr;
  logic [1:0]  fresh_add;

  always_comb begin
    hi_word = s_hi_ok ? shift_rd : 64'd0;
    plain_w = s_lv0 ? 64'd0 : plain_rd;
    once_w  = s_lv0 ? 64'd0 : sum_rd[63:0];
    twice_w = s_lv0 ? 64'd0 : sum_rd[127:64];
    if (bsh == 6'd0) begin
      fnew = hi_word;
    end else begin
      fnew = (hi_word << bsh) | (prev >> (7'd64 - 7'(bsh)));
    end
    if (x2[15:6] == 10'(s_idx)) begin
      fnew = fnew | (64'd1 << x2[5:0]);
    end
    hits = once_w & fnew;
    fr   = hits & ~twice_w;
    if (fr == 64'd0) begin
      fresh_add = 2'd0;
    end else if ((fr & (fr - 64'd1)) != 64'd0) begin
      fresh_add = 2'd2;
    end else begin
      fresh_add = 2'd1;
    end
    member_wdata = plain_w;
    if (ws == 10'(s_idx)) begin
      member_wdata = plain_w | (64'd1 << bsh);
    end
    sum_wdata = {twice_w | hits, (once_w | fnew) & ~hits};
  end

  // histogram pass decode
  logic          last_j, last_i;
  logic [VW-1:0] v_now;
  logic [6:0]    hcnt;
  logic [VW-1:0] peak_fin;
  logic [6:0]    cnt_fin;
  logic [7:0]    inv;
  state_t        adv_state;

  assign last_j   = (7'(hj) + 7'd1) >= set_size;
  assign last_i   = (7'(hi) + 7'd1) >= set_size;
  assign v_now    = VW'(ai) + VW'(stk_rd);
  assign hcnt     = hist_rd + 7'd1;
  assign peak_fin = (pk_cnt < 7'd2) ? '0 : peak;
  assign cnt_fin  = (pk_cnt < 7'd2) ? 7'd1 : pk_cnt;
  assign inv      = {cnt_fin, 1'b0} - {1'b0, set_size};

  always_comb begin
    if (!last_j) begin
      adv_state = ST_HJ_RD;
    end else if (!last_i || !pass) begin
      adv_state = ST_HI_RD;
    end else begin
      adv_state = ST_OUT_RD;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (req.valid) state_next = ST_STEP;
      ST_STEP: begin
        if (size_bad) begin
          state_next = ST_STATUS;
        end else if (depth > set_size) begin
          state_next = ST_POP_RD;
        end else if (depth == set_size) begin
          state_next = ST_HI_RD;
        end else if (sets_reported >= max_sets) begin
          state_next = ST_STATUS;
        end else if (out_range) begin
          state_next = (depth == 7'd0) ? ST_STATUS : ST_POP_RD;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_POP_RD: state_next = ST_POP_WT;
      ST_POP_WT: state_next = pop_idle ? ST_IDLE : ST_STEP;
      ST_SCAN:   if (w == WW'(WORDS) && !s_val) state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_STEP;
      ST_HI_RD:  state_next = ST_HI_WT;
      ST_HI_WT:  state_next = ST_HJ_RD;
      ST_HJ_RD:  state_next = ST_HV;
      ST_HV:     state_next = pass ? ST_HW : adv_state;
      ST_HW:     state_next = adv_state;
      ST_OUT_RD: if (rsp_free) state_next = ST_OUT_LD;
      ST_OUT_LD: state_next = (7'(oi) + 7'd1 >= set_size) ? ST_POP_RD : ST_OUT_RD;
      ST_STATUS: if (rsp_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    shift_we    = (state == ST_SCAN) && s_val;
    shift_waddr = base_up + AW'(s_idx);
    shift_raddr = base + AW'(w) - AW'(ws);
    plain_raddr = base + AW'(w);
    stk_we      = (state == ST_DECIDE) && !reject;
    stk_waddr   = SAW'(depth);
    stk_wdata   = EW'(x);
    case (state)
      ST_POP_RD: stk_raddr = SAW'(depth - 7'd1);
      ST_HI_RD:  stk_raddr = hi;
      ST_HJ_RD:  stk_raddr = hj;
      ST_OUT_RD: stk_raddr = oi;
      default:   stk_raddr = '0;
    endcase
    hist_we    = ((state == ST_HV) && !pass) || (state == ST_HW);
    hist_waddr = (state == ST_HW) ? hv : v_now;
    hist_wdata = (state == ST_HW) ? hcnt : 7'd0;
    hist_raddr = v_now;
  end

  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = rsp_valid;
  assign rsp.word  = rsp_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      element_limit <= LIMIT_RST;
      set_size      <= SIZE_RST;
      max_sets      <= MAX_SETS_RST;
      depth         <= 7'd0;
      cur           <= XW'(1);
      sets_reported <= 32'd0;
      rsp_valid     <= 1'b0;
      s_val         <= 1'b0;
      w             <= '0;
      pop_idle      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        case (cfg.word.index)
          REG_ELEMENT_LIMIT: element_limit <= cfg.word.value[8:0];
          REG_SET_SIZE:      set_size      <= cfg.word.value[6:0];
          REG_MAX_SETS:      max_sets      <= cfg.word.value;
          default: ;
        endcase
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid && req.word.restart) begin
            depth         <= 7'd0;
            cur           <= XW'(1);
            sets_reported <= 32'd0;
          end
        end
        ST_STEP: begin
          pop_idle  <= 1'b0;
          stat_code <= (!size_bad && depth < set_size && sets_reported >= max_sets) ?
                       STAT_LIMIT : STAT_EXHAUSTED;
          hi     <= '0;
          pass   <= 1'b0;
          peak   <= '0;
          pk_cnt <= 7'd0;
          oi     <= '0;
          x      <= cur;
          if (state_next == ST_SCAN) begin
            cur <= cur + XW'(1);
          end
          w      <= '0;
          s_val  <= 1'b0;
          prev   <= 64'd0;
          fresh  <= 2'd0;
          excl   <= 1'b0;
        end
        ST_POP_WT: begin
          depth <= depth - 7'd1;
          cur   <= XW'(stk_rd) + XW'(1);
        end
        ST_SCAN: begin
          if (w != WW'(WORDS)) begin
            s_val   <= 1'b1;
            s_idx   <= w;
            s_hi_ok <= (10'(w) >= ws) && (depth != 7'd0);
            s_lv0   <= (depth == 7'd0);
            w       <= w + WW'(1);
          end else begin
            s_val <= 1'b0;
          end
          if (s_val) begin
            prev <= hi_word;
            if (twice_w != 64'd0) excl <= 1'b1;
            if (3'(fresh) + 3'(fresh_add) >= 3'd2) begin
              fresh <= 2'd2;
            end else begin
              fresh <= fresh + fresh_add;
            end
          end
        end
        ST_DECIDE: begin
          if (!reject) begin
            depth <= depth + 7'd1;
          end else begin
            cur <= x + XW'(1);
          end
        end
        ST_HI_WT: begin
          ai <= stk_rd;
          hj <= hi;
        end
        ST_HV, ST_HW: begin
          if (state == ST_HV) begin
            hv <= v_now;
          end else if ((hcnt > pk_cnt) || ((hcnt == pk_cnt) && (hv < peak))) begin
            pk_cnt <= hcnt;
            peak   <= hv;
          end
          if ((state == ST_HW) || !pass) begin
            if (!last_j) begin
              hj <= hj + SAW'(1);
            end else if (!last_i) begin
              hi <= hi + SAW'(1);
            end else begin
              hi   <= '0;
              pass <= 1'b1;
            end
          end
        end
        ST_OUT_LD: begin
          rsp_word.status     <= STAT_FOUND;
          rsp_word.element    <= 9'(stk_rd);
          rsp_word.position   <= 6'(oi);
          rsp_word.is_last    <= (7'(oi) + 7'd1 >= set_size);
          rsp_word.peak_sum   <= 10'(peak_fin);
          rsp_word.peak_count <= cnt_fin;
          rsp_word.invariant  <= inv;
          rsp_word.anomaly    <= !inv[7] && (inv >= 8'd2);
          oi                  <= oi + SAW'(1);
          if (7'(oi) + 7'd1 >= set_size) begin
            sets_reported <= sets_reported + 32'd1;
            pop_idle      <= 1'b1;
          end
        end
        ST_STATUS: begin
          if (rsp_free) begin
            rsp_word.status     <= stat_code;
            rsp_word.element    <= 9'd0;
            rsp_word.position   <= 6'd0;
            rsp_word.is_last    <= 1'b1;
            rsp_word.peak_sum   <= 10'd0;
            rsp_word.peak_count <= 7'd1;
            rsp_word.invariant  <= 8'sd0;
            rsp_word.anomaly    <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= 7'(MAX_SET_SIZE))
    else $error("search depth beyond the stack");

  a_cursor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP) |-> (cur != '0))
    else $error("candidate cursor is zero");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == ST_OUT_LD || $past(state) == ST_STATUS))
    else $error("response word loaded outside output states");

endmodule

@@ rtl/asss_ram.sv @@
// Generic single write port RAM with one registered read port.
module asss_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
